### sv/msss_pkg.sv
// shared widths and result codes for the mirrored stripe seek scheduler
package msss_pkg;

    localparam int PAGE_BITS   = 24;
    localparam int TS_BITS     = 32;
    localparam int CNT_BITS    = 32;
    localparam int NDISK_BITS  = 5;
    localparam int DISK_IDX_W  = 4;
    localparam int OUTCOME_W   = 3;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NEW_SLOT  = 3'd0,
        OUT_SEQ_PRI   = 3'd1,
        OUT_SEQ_MIR   = 3'd2,
        OUT_PLACE_PRI = 3'd3,
        OUT_PLACE_MIR = 3'd4,
        OUT_CONFLICT  = 3'd5
    } t_outcome;

endpackage

### sv/msss_req_if.sv
// request channel: mode, logical page and arrival time
interface msss_req_if
    import msss_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [PAGE_BITS-1:0] page_number;
    logic [TS_BITS-1:0]   timestamp;

    modport source (output valid, mode, page_number, timestamp, input ready);
    modport sink   (input valid, mode, page_number, timestamp, output ready);
endinterface

### sv/msss_rsp_if.sv
// result channel: placement, outcome and running counters
interface msss_rsp_if
    import msss_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [DISK_IDX_W-1:0] disk_index;
    logic [PAGE_BITS-1:0]  physical_page;
    logic [OUTCOME_W-1:0]  outcome;
    logic [CNT_BITS-1:0]   seek_count;
    logic [TS_BITS-1:0]    current_time;
    logic [CNT_BITS-1:0]   read_count;
    logic [CNT_BITS-1:0]   write_count;

    modport source (output valid, disk_index, physical_page, outcome, seek_count,
                    current_time, read_count, write_count, input ready);
    modport sink   (input valid, disk_index, physical_page, outcome, seek_count,
                    current_time, read_count, write_count, output ready);
endinterface

### sv/msss_div.sv
// radix-2 restoring divider: page number by disk count, one quotient bit a cycle
module msss_div
    import msss_pkg::*;
#(
    parameter int MAX_DISKS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [PAGE_BITS-1:0]         i_dividend,
    input  logic [$clog2(MAX_DISKS+1)-1:0] i_divisor,
    output logic                         o_done,
    output logic [PAGE_BITS-1:0]         o_quot,
    output logic [$clog2(MAX_DISKS+1)-1:0] o_rem
);
    localparam int NW = $clog2(MAX_DISKS + 1);
    localparam int CW = $clog2(PAGE_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [PAGE_BITS-1:0] r_quot;
    logic [NW-1:0]        r_rem;
    logic [NW-1:0]        r_div;

    logic [NW:0]          c_trial;
    logic                 c_bit;
    logic [NW:0]          c_rem;

    always_comb begin
        c_trial = {r_rem, r_quot[PAGE_BITS-1]};
        c_bit   = (c_trial >= {1'b0, r_div});
        c_rem   = c_bit ? (c_trial - {1'b0, r_div}) : c_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(PAGE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[PAGE_BITS-2:0], c_bit};
            r_rem  <= c_rem[NW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

### sv/msss_page_mem.sv
// last-page table per disk copy: dual read, single write, entries read zero until written
module msss_page_mem
    import msss_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [PAGE_BITS-1:0]     o_rd_data_a,
    output logic [PAGE_BITS-1:0]     o_rd_data_b,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [PAGE_BITS-1:0]     i_wr_data
);
    logic [PAGE_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_vld;
    logic [PAGE_BITS-1:0] r_rd_a;
    logic [PAGE_BITS-1:0] r_rd_b;
    logic                 r_vld_a;
    logic                 r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    // valid bits stand in for the all-zero reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_vld[i_rd_addr_a];
                r_vld_b <= r_vld[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_vld_a ? r_rd_a : '0;
    assign o_rd_data_b = r_vld_b ? r_rd_b : '0;
endmodule

### sv/mirrored_stripe_seek_scheduler.sv
// top level: request sequencing, free bits, slot and counters of the seek scheduler
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        mode, page_number, timestamp
//  o_rsp     out  valid/ready        disk_index, physical_page, outcome, 4 counters
//  i_cfg_*   in   write enable only  num_disks (5 bits)
//
// a request passes through S_DIV, S_READ, S_DECIDE and, for writes, S_WR2 before it
// returns to idle; S_DIV holds the bit-serial divide of the page by the disk count
// the result register frees the request side: a new request is taken while a
// result waits, and its update stalls only until that result is taken
// synchronous active-low reset: all copies free, table reads zero, counters zero
module mirrored_stripe_seek_scheduler
    import msss_pkg::*;
#(
    parameter int MAX_DISKS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [NDISK_BITS-1:0] i_cfg_wr_data,
    msss_req_if.sink              i_req,
    msss_rsp_if.source            o_rsp
);
    localparam int NW = $clog2(MAX_DISKS + 1);
    localparam int DW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int FW = 2 * MAX_DISKS;
    localparam int AW = $clog2(FW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_DECIDE,
        S_WR2
    } t_state;

    function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                     input logic [1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + (CNT_BITS+1)'(b);
        return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
    endfunction

    t_state                r_state;
    logic [NDISK_BITS-1:0] r_num_disks;
    logic [NW-1:0]         r_n;
    logic                  r_mode;
    logic [PAGE_BITS-1:0]  r_page;
    logic [TS_BITS-1:0]    r_ts;
    logic [DW-1:0]         r_d;
    logic [AW-1:0]         r_m;
    logic [PAGE_BITS-1:0]  r_p;
    logic [FW-1:0]         r_free;
    logic [TS_BITS-1:0]    r_slot;
    logic [CNT_BITS-1:0]   r_seeks;
    logic [CNT_BITS-1:0]   r_reads;
    logic [CNT_BITS-1:0]   r_writes;
    logic                  r_div_start;

    logic                  r_out_valid;
    logic [DISK_IDX_W-1:0] r_out_disk;
    logic [PAGE_BITS-1:0]  r_out_page;
    t_outcome              r_out_outcome;

    logic                  div_done;
    logic [PAGE_BITS-1:0]  div_quot;
    logic [NW-1:0]         div_rem;
    logic [PAGE_BITS-1:0]  lp_d;
    logic [PAGE_BITS-1:0]  lp_m;

    logic [AW-1:0]         c_dx;
    logic [NW-1:0]         c_n_eff;
    logic                  c_seq_d;
    logic                  c_seq_m;
    logic                  c_free_d;
    logic                  c_free_m;
    logic                  c_ts_new;
    t_outcome              c_outcome;
    logic                  c_open;
    logic [TS_BITS-1:0]    c_slot;
    logic                  c_busy_d;
    logic                  c_busy_m;
    logic                  c_wr_mir;
    logic [FW-1:0]         c_open_mask;
    logic [FW-1:0]         c_free_next;
    logic                  c_commit;
    logic                  c_req_acc;
    logic                  mem_rd_en;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;

    // disk count zero acts as one, above the table size it is clamped
    always_comb begin
        if (r_num_disks == '0) begin
            c_n_eff = NW'(1);
        end else if (int'(r_num_disks) > MAX_DISKS) begin
            c_n_eff = NW'(MAX_DISKS);
        end else begin
            c_n_eff = NW'(r_num_disks);
        end
    end

    msss_div #(
        .MAX_DISKS (MAX_DISKS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_page),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign c_dx = AW'(r_d);

    msss_page_mem #(
        .DEPTH (FW)
    ) u_page_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (mem_rd_en),
        .i_rd_addr_a (c_dx),
        .i_rd_addr_b (r_m),
        .o_rd_data_a (lp_d),
        .o_rd_data_b (lp_m),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (r_p)
    );

    // scheduling decision from the table entries of both copies
    always_comb begin
        c_seq_d  = ({1'b0, lp_d} + (PAGE_BITS+1)'(1)) == {1'b0, r_p};
        c_seq_m  = ({1'b0, lp_m} + (PAGE_BITS+1)'(1)) == {1'b0, r_p};
        c_free_d = r_free[c_dx];
        c_free_m = r_free[r_m];
        c_ts_new = r_ts > r_slot;

        c_outcome = OUT_CONFLICT;
        c_open    = 1'b0;
        c_slot    = r_slot;
        c_busy_d  = 1'b0;
        c_busy_m  = 1'b0;
        c_wr_mir  = 1'b0;

        if (!r_mode) begin
            priority if (c_ts_new) begin
                c_outcome = OUT_NEW_SLOT;
                c_open    = 1'b1;
                c_slot    = r_ts;
                c_busy_d  = 1'b1;
            end else if (c_seq_d) begin
                c_outcome = OUT_SEQ_PRI;
            end else if (c_seq_m) begin
                c_outcome = OUT_SEQ_MIR;
                c_wr_mir  = 1'b1;
            end else if (c_free_d) begin
                c_outcome = OUT_PLACE_PRI;
                c_busy_d  = 1'b1;
            end else if (c_free_m) begin
                c_outcome = OUT_PLACE_MIR;
                c_busy_m  = 1'b1;
                c_wr_mir  = 1'b1;
            end else begin
                c_outcome = OUT_CONFLICT;
                c_open    = 1'b1;
                c_slot    = sat_add(r_slot, 2'd1);
                c_busy_d  = 1'b1;
            end
        end else begin
            priority if (c_ts_new) begin
                c_outcome = OUT_NEW_SLOT;
                c_open    = 1'b1;
                c_slot    = r_ts;
            end else if (c_seq_d && c_seq_m) begin
                c_outcome = OUT_SEQ_PRI;
            end else if (c_free_d && c_free_m) begin
                c_outcome = OUT_PLACE_PRI;
            end else begin
                c_outcome = OUT_CONFLICT;
                c_open    = 1'b1;
                c_slot    = sat_add(r_slot, 2'd1);
            end
            c_busy_d = (c_outcome != OUT_SEQ_PRI);
            c_busy_m = (c_outcome != OUT_SEQ_PRI);
        end

        // a new slot frees copies 0 .. 2n-1 only
        for (int i = 0; i < FW; i++) begin
            c_open_mask[i] = c_open && (i < 2 * int'(r_n));
        end
        c_free_next = (r_free | c_open_mask)
                    & ~({FW{c_busy_d}} & (FW'(1) << c_dx))
                    & ~({FW{c_busy_m}} & (FW'(1) << r_m));
    end

    assign c_commit  = (r_state == S_DECIDE) && (!r_out_valid || o_rsp.ready);
    assign c_req_acc = i_req.valid && i_req.ready;
    assign mem_rd_en = (r_state == S_READ);
    assign mem_wr_en = c_commit || (r_state == S_WR2);
    assign mem_wr_addr = ((r_state == S_WR2) || c_wr_mir) ? r_m : c_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_disks <= NDISK_BITS'(4);
            r_free      <= '1;
            r_slot      <= '0;
            r_seeks     <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= c_req_acc;
            if (i_cfg_wr_en) begin
                r_num_disks <= i_cfg_wr_data;
            end
            if (c_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (c_req_acc) begin
                        r_mode      <= i_req.mode;
                        r_page      <= i_req.page_number;
                        r_ts        <= i_req.timestamp;
                        r_n         <= c_n_eff;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_d     <= DW'(div_rem);
                        r_m     <= AW'(div_rem) + AW'(r_n);
                        r_p     <= div_quot;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (c_commit) begin
                        r_free  <= c_free_next;
                        r_slot  <= c_slot;
                        if (c_open) begin
                            r_seeks <= sat_add(r_seeks, 2'd1);
                        end
                        if (r_mode) begin
                            r_writes <= sat_add(r_writes, 2'd2);
                        end else begin
                            r_reads  <= sat_add(r_reads, 2'd1);
                        end
                        r_out_disk    <= DISK_IDX_W'(r_d);
                        r_out_page    <= r_p;
                        r_out_outcome <= c_outcome;
                        r_state       <= r_mode ? S_WR2 : S_IDLE;
                    end
                end
                S_WR2: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.disk_index    = r_out_disk;
    assign o_rsp.physical_page = r_out_page;
    assign o_rsp.outcome       = r_out_outcome;
    assign o_rsp.seek_count    = r_seeks;
    assign o_rsp.current_time  = r_slot;
    assign o_rsp.read_count    = r_reads;
    assign o_rsp.write_count   = r_writes;
endmodule

### test/mirrored_stripe_seek_scheduler_tb.sv
// self-checking testbench for the mirrored stripe seek scheduler: predictor, driver and monitor
module mirrored_stripe_seek_scheduler_tb;
    import msss_pkg::*;

    localparam int DISK_LIMIT   = 16;
    localparam int SETTLE       = 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int SHOW_MAX     = 10;

    typedef struct packed {
        logic                 mode;
        logic [PAGE_BITS-1:0] page;
        logic [TS_BITS-1:0]   ts;
    } req_item_t;

    typedef struct packed {
        logic [DISK_IDX_W-1:0] disk;
        logic [PAGE_BITS-1:0]  ppage;
        t_outcome              outcome;
        logic [CNT_BITS-1:0]   seeks;
        logic [TS_BITS-1:0]    now;
        logic [CNT_BITS-1:0]   reads;
        logic [CNT_BITS-1:0]   writes;
    } seek_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [NDISK_BITS-1:0] i_cfg_wr_data;

    msss_req_if req_ch ();
    msss_rsp_if rsp_ch ();

    mirrored_stripe_seek_scheduler #(
        .MAX_DISKS(DISK_LIMIT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req        (req_ch.sink),
        .o_rsp        (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // predicted scheduler state
    logic [NDISK_BITS-1:0] disk_cfg = 5'd4;
    bit                    copy_free [2*DISK_LIMIT];
    logic [PAGE_BITS-1:0]  copy_last [2*DISK_LIMIT];
    logic [TS_BITS-1:0]    slot_now;
    logic [CNT_BITS-1:0]   seeks_ctr;
    logic [CNT_BITS-1:0]   reads_ctr;
    logic [CNT_BITS-1:0]   writes_ctr;

    req_item_t    req_backlog [$];
    seek_result_t due_results [$];

    int src_gap     = 0;
    int snk_gap     = 0;
    int src_pct     = 0;
    int snk_pct     = 0;
    int hold_left   = 0;
    logic hold_go;
    int err_count   = 0;
    int req_taken   = 0;
    int rsp_taken   = 0;
    int settings_cnt = 1;
    int outcome_seen [6];

    // sequential runs used by the random stimulus
    int unsigned run_disk [4];
    int unsigned run_page [4];

    function automatic int unsigned active_disks();
        if (disk_cfg == 0)
            return 1;
        if (disk_cfg > DISK_LIMIT)
            return DISK_LIMIT;
        return 32'(disk_cfg);
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] a, input logic [1:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {31'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // no wrap: a last page of all ones never continues
    function automatic bit follows(input logic [PAGE_BITS-1:0] last,
                                   input logic [PAGE_BITS-1:0] p);
        return ({1'b0, last} + 25'd1) == {1'b0, p};
    endfunction

    task automatic new_slot(input int unsigned n);
        int unsigned i;
        for (i = 0; i < 2 * n; i++)
            copy_free[i] = 1'b1;
        seeks_ctr = bump(seeks_ctr, 2'd1);
    endtask

    task automatic schedule_request(input req_item_t rq);
        int unsigned  n, d, m;
        logic [PAGE_BITS-1:0] p;
        t_outcome     oc;
        seek_result_t res;
        n = active_disks();
        d = rq.page % n;
        p = PAGE_BITS'(rq.page / n);
        m = d + n;
        if (!rq.mode) begin
            reads_ctr = bump(reads_ctr, 2'd1);
            if (rq.ts > slot_now) begin
                new_slot(n);
                slot_now = rq.ts;
                copy_free[d] = 1'b0;
                copy_last[d] = p;
                oc = OUT_NEW_SLOT;
            end else if (follows(copy_last[d], p)) begin
                copy_last[d] = p;
                oc = OUT_SEQ_PRI;
            end else if (follows(copy_last[m], p)) begin
                copy_last[m] = p;
                oc = OUT_SEQ_MIR;
            end else if (copy_free[d]) begin
                copy_free[d] = 1'b0;
                copy_last[d] = p;
                oc = OUT_PLACE_PRI;
            end else if (copy_free[m]) begin
                copy_free[m] = 1'b0;
                copy_last[m] = p;
                oc = OUT_PLACE_MIR;
            end else begin
                new_slot(n);
                slot_now = bump(slot_now, 2'd1);
                copy_free[d] = 1'b0;
                copy_last[d] = p;
                oc = OUT_CONFLICT;
            end
        end else begin
            writes_ctr = bump(writes_ctr, 2'd2);
            if (rq.ts > slot_now) begin
                new_slot(n);
                slot_now = rq.ts;
                oc = OUT_NEW_SLOT;
            end else if (follows(copy_last[d], p) && follows(copy_last[m], p)) begin
                oc = OUT_SEQ_PRI;
            end else if (copy_free[d] && copy_free[m]) begin
                oc = OUT_PLACE_PRI;
            end else begin
                new_slot(n);
                slot_now = bump(slot_now, 2'd1);
                oc = OUT_CONFLICT;
            end
            if (oc != OUT_SEQ_PRI) begin
                copy_free[d] = 1'b0;
                copy_free[m] = 1'b0;
            end
            copy_last[d] = p;
            copy_last[m] = p;
        end
        res.disk    = d[DISK_IDX_W-1:0];
        res.ppage   = p;
        res.outcome = oc;
        res.seeks   = seeks_ctr;
        res.now     = slot_now;
        res.reads   = reads_ctr;
        res.writes  = writes_ctr;
        due_results.push_back(res);
    endtask

    // request driver
    always @(posedge i_clk) begin
        req_item_t nxt;
        if (req_ch.valid && req_ch.ready) begin
            schedule_request({req_ch.mode, req_ch.page_number, req_ch.timestamp});
            req_taken++;
        end
        if (req_ch.valid && !req_ch.ready) begin
            // hold the offered request until taken
        end else if (src_gap != 0) begin
            src_gap <= src_gap - 1;
            req_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
            nxt = req_backlog.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.mode        <= nxt.mode;
            req_ch.page_number <= nxt.page;
            req_ch.timestamp   <= nxt.ts;
            if (src_pct != 0 && $urandom_range(99) < src_pct)
                src_gap <= $urandom_range(1, 12);
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge i_clk) begin
        seek_result_t got, want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            got.disk    = rsp_ch.disk_index;
            got.ppage   = rsp_ch.physical_page;
            got.outcome = t_outcome'(rsp_ch.outcome);
            got.seeks   = rsp_ch.seek_count;
            got.now     = rsp_ch.current_time;
            got.reads   = rsp_ch.read_count;
            got.writes  = rsp_ch.write_count;
            rsp_taken++;
            if (rsp_ch.outcome <= OUT_CONFLICT)
                outcome_seen[rsp_ch.outcome]++;
            if (due_results.size() == 0) begin
                err_count++;
                if (err_count <= SHOW_MAX)
                    $display("unexpected result: disk %0d page %h outcome %0d",
                             got.disk, got.ppage, rsp_ch.outcome);
            end else begin
                want = due_results.pop_front();
                if (got.disk !== want.disk || got.ppage !== want.ppage ||
                    got.outcome !== want.outcome || got.seeks !== want.seeks ||
                    got.now !== want.now || got.reads !== want.reads ||
                    got.writes !== want.writes) begin
                    err_count++;
                    if (err_count <= SHOW_MAX) begin
                        $display("mismatch at result %0d:", rsp_taken);
                        $display("  got  disk %0d page %h outcome %0d seeks %0d time %h rd %0d wr %0d",
                                 got.disk, got.ppage, got.outcome, got.seeks,
                                 got.now, got.reads, got.writes);
                        $display("  want disk %0d page %h outcome %0d seeks %0d time %h rd %0d wr %0d",
                                 want.disk, want.ppage, want.outcome, want.seeks,
                                 want.now, want.reads, want.writes);
                    end
                end
            end
        end
        if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap <= snk_gap - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (snk_pct != 0 && $urandom_range(99) < snk_pct)
                snk_gap <= $urandom_range(1, 12);
        end
    end

    initial begin
        int unsigned watch;
        for (watch = 0; watch < LIMIT_CYCLES; watch++)
            @(posedge i_clk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic push_req(input logic md, input logic [PAGE_BITS-1:0] pg,
                            input logic [TS_BITS-1:0] ts);
        while (req_backlog.size() >= 2)
            @(posedge i_clk);
        req_backlog.push_back({md, pg, ts});
    endtask

    // checked on the falling edge so that every rising-edge update has landed
    task automatic drain();
        while (req_backlog.size() != 0 || req_ch.valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_disks(input logic [NDISK_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        disk_cfg = v;
        settings_cnt++;
    endtask

    task automatic fresh_run(input int s, input int unsigned n);
        int unsigned top;
        run_disk[s] = $urandom_range(0, n - 1);
        top = (32'h00FF_FFFF - run_disk[s]) / n;
        case ($urandom_range(3))
            0, 1:    run_page[s] = $urandom_range(0, 200);
            2:       run_page[s] = top - $urandom_range(0, 2);
            default: run_page[s] = $urandom_range(0, top);
        endcase
    endtask

    task automatic push_random(input int count);
        int unsigned n, r, pg, back;
        int s, k;
        logic [TS_BITS-1:0] ts;
        logic md;
        n = active_disks();
        for (s = 0; s < 4; s++)
            fresh_run(s, n);
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                s = $urandom_range(0, 3);
                if (run_page[s] * n + run_disk[s] > 32'h00FF_FFFF || $urandom_range(15) == 0)
                    fresh_run(s, n);
                pg = run_page[s] * n + run_disk[s];
                run_page[s]++;
            end else if (r < 75) begin
                // four pages per disk: crowds the copies and forces conflicts
                pg = $urandom_range(0, 4 * n - 1);
            end else if (r < 95) begin
                pg = $urandom & 32'h00FF_FFFF;
            end else if ($urandom_range(1) == 0) begin
                pg = 32'h00FF_FFFF - $urandom_range(0, n);
            end else begin
                pg = $urandom_range(0, n);
            end
            md = ($urandom_range(99) < 30);
            r = $urandom_range(99);
            if (r < 10) begin
                ts = bump(slot_now, 2'($urandom_range(1, 3)));
            end else if (r < 14) begin
                ts = $urandom;
            end else begin
                back = (slot_now < 4) ? slot_now : 4;
                ts = slot_now - $urandom_range(0, back);
            end
            push_req(md, pg[PAGE_BITS-1:0], ts);
        end
    endtask

    initial begin
        int i, fails;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        hold_go             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = 1'b0;
        req_ch.page_number  = '0;
        req_ch.timestamp    = '0;
        rsp_ch.ready        = 1'b0;
        for (i = 0; i < 2 * DISK_LIMIT; i++) begin
            copy_free[i] = 1'b1;
            copy_last[i] = '0;
        end
        for (i = 0; i < 6; i++)
            outcome_seen[i] = 0;
        slot_now   = '0;
        seeks_ctr  = '0;
        reads_ctr  = '0;
        writes_ctr = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_pct = 25;
        snk_pct = 25;

        // four disks out of reset: every outcome in a known order
        push_req(1'b0, 24'd0,   32'd0);
        push_req(1'b0, 24'd4,   32'd0);
        push_req(1'b0, 24'd0,   32'd0);
        push_req(1'b0, 24'd4,   32'd0);
        push_req(1'b0, 24'd8,   32'd0);
        push_req(1'b0, 24'd100, 32'd0);
        push_req(1'b1, 24'd1,   32'd0);
        push_req(1'b1, 24'd5,   32'd0);
        push_req(1'b1, 24'd1,   32'd0);
        push_req(1'b0, 24'd3,   32'd10);
        push_req(1'b1, 24'd2,   32'd20);
        push_req(1'b1, 24'hFF_FFFF, 32'd5);
        drain();

        // one disk: last page of all ones must not continue into page zero
        write_disks(5'd1);
        push_req(1'b0, 24'hFF_FFFF, 32'd0);
        push_req(1'b0, 24'd0,       32'd0);
        push_req(1'b0, 24'hFF_FFFF, 32'd0);
        drain();

        // zero disks acts as one
        write_disks(5'd0);
        push_req(1'b0, 24'h00_0001, 32'd0);
        push_req(1'b1, 24'h00_0002, 32'd0);
        push_random(100);
        drain();

        // over-range count acts as the maximum; receiver holds off while requests pile up
        write_disks(5'd31);
        src_pct = 0;
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        push_req(1'b0, 24'hFF_FFFF, 32'd0);
        push_req(1'b1, 24'h00_000F, 32'd0);
        push_random(120);
        drain();

        src_pct = 0;
        snk_pct = 0;
        write_disks(5'd16);
        push_random(120);
        drain();

        src_pct = 30;
        snk_pct = 10;
        write_disks(5'd3);
        push_random(120);
        drain();

        src_pct = 10;
        snk_pct = 30;
        write_disks(5'($urandom_range(1, 16)));
        push_random(120);
        drain();

        src_pct = 20;
        snk_pct = 20;
        write_disks(5'd7);
        push_random(120);
        drain();

        // last stretch at full rate: slot time pinned at its ceiling, then conflicts
        src_pct = 0;
        snk_pct = 0;
        write_disks(5'd2);
        push_req(1'b0, 24'd0, 32'hFFFF_FFFF);
        push_req(1'b0, 24'd4, 32'hFFFF_FFFF);
        push_req(1'b0, 24'd8, 32'hFFFF_FFFF);
        push_req(1'b1, 24'd1, 32'hFFFF_FFFF);
        push_req(1'b1, 24'd3, 32'h0000_0000);
        push_random(150);
        drain();

        fails = err_count + due_results.size();
        $display("checked %0d of %0d requests over %0d disk-count settings", rsp_taken,
                 req_taken, settings_cnt);
        $display("outcomes: new slot %0d, seq %0d, seq mirror %0d, placed %0d, mirror %0d, conflict %0d",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4], outcome_seen[5]);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### mirrored_stripe_seek_scheduler.f
sv/msss_pkg.sv
sv/msss_req_if.sv
sv/msss_rsp_if.sv
sv/msss_div.sv
sv/msss_page_mem.sv
sv/mirrored_stripe_seek_scheduler.sv
test/mirrored_stripe_seek_scheduler_tb.sv
